[hdl/mse_pkg.sv]
// Package for the merge sort engine: sizes and the beat types of both channels.
// Depends on nothing; imported by merge_sort_engine.
`timescale 1ns / 1ps

package mse_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W      = CNT_W + 2;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         end_of_set;
    logic                         overflow;
  } out_beat_t;

endpackage

[hdl/merge_sort_engine.sv]
// Merge sort engine: collects a set, sorts it by bottom-up merge passes between
// two buffer memories and emits it in ascending order. Depends on mse_pkg.
`timescale 1ns / 1ps
//
//  channel  | ports                   | handshake
//  ---------+-------------------------+-------------------------------------
//  input    | item (in_beat_t)        | beat taken when start && !busy
//  result   | result (out_beat_t)     | beat valid for one cycle on strobe
//
//  Loading takes one beat per cycle while idle. After the last beat the set of
//  n elements is merged in ceil(log2 n) passes; per run pair the heads of both
//  runs are read, then each merge step writes one element and reads the next
//  of its run through the single read port of the source buffer. Emission then
//  reads and shows each result in turn. busy rises after the last beat and
//  falls in the cycle after the final result. Synchronous reset clears control
//  state; the buffers are not cleared. The receiver cannot stall results.

module merge_sort_engine
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_beat_t  item,
  output logic      busy,
  output logic      strobe,
  output out_beat_t result
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_SETUP    = 9'b000000010,
    S_RDA      = 9'b000000100,
    S_RDB      = 9'b000001000,
    S_MERGE    = 9'b000010000,
    S_FILLA    = 9'b000100000,
    S_FILLB    = 9'b001000000,
    S_EMIT_RD  = 9'b010000000,
    S_EMIT_OUT = 9'b100000000
  } state_t;

  state_t state;

  logic [CNT_W-1:0] count;
  logic             ovf;
  logic             sel;          // 0: source is buf0, 1: source is buf1
  logic [SUM_W-1:0] w;
  logic [CNT_W-1:0] lo, mid, hi, i, j, k, e;
  logic signed [DATA_WIDTH-1:0] a, b;

  logic [DATA_WIDTH-1:0] buf0 [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] buf1 [MAX_ITEMS];
  logic [DATA_WIDTH-1:0] rd0, rd1;
  logic signed [DATA_WIDTH-1:0] rdata;

  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  we0, we1;

  logic [SUM_W-1:0] n_ext, lo_w, lo_2w, w2;
  logic [CNT_W-1:0] mid_c, hi_c, i_inc, j_inc, k_inc, e_inc, count_after;
  logic             room, a_ok, b_ok, take_a;

  assign n_ext = SUM_W'(count);
  assign lo_w  = SUM_W'(lo) + w;
  assign w2    = w << 1;
  assign lo_2w = SUM_W'(lo) + w2;
  assign mid_c = (lo_w < n_ext) ? lo_w[CNT_W-1:0] : count;
  assign hi_c  = (lo_2w < n_ext) ? lo_2w[CNT_W-1:0] : count;

  assign i_inc = i + CNT_W'(1);
  assign j_inc = j + CNT_W'(1);
  assign k_inc = k + CNT_W'(1);
  assign e_inc = e + CNT_W'(1);

  assign room        = count < CNT_W'(MAX_ITEMS);
  assign count_after = room ? count + CNT_W'(1) : count;

  // On a tie take the right-hand run first.
  assign a_ok   = i < mid;
  assign b_ok   = j < hi;
  assign take_a = a_ok && (!b_ok || (a < b));

  assign rdata = sel ? $signed(rd1) : $signed(rd0);

  always_comb begin
    unique case (state)
      S_SETUP:   rd_addr = lo[ADDR_W-1:0];
      S_RDA:     rd_addr = j[ADDR_W-1:0];
      S_MERGE:   rd_addr = take_a ? i_inc[ADDR_W-1:0] : j_inc[ADDR_W-1:0];
      S_EMIT_RD: rd_addr = e[ADDR_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  // Reads come from the source buffer, writes go to the other one, so no entry
  // is read and written in the same pass.
  assign wr_addr = (state == S_IDLE) ? count[ADDR_W-1:0] : k[ADDR_W-1:0];
  assign wr_data = (state == S_IDLE) ? item.value : (take_a ? a : b);
  assign we0     = ((state == S_IDLE) && start && room) || ((state == S_MERGE) && sel);
  assign we1     = (state == S_MERGE) && !sel;

  always_ff @(posedge clk) begin
    if (we0) begin
      buf0[wr_addr] <= wr_data;
    end
    rd0 <= buf0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      buf1[wr_addr] <= wr_data;
    end
    rd1 <= buf1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      ovf   <= 1'b0;
      sel   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (room) begin
              count <= count_after;
            end else begin
              ovf <= 1'b1;
            end
            if (item.is_last) begin
              sel <= 1'b0;
              w   <= SUM_W'(1);
              lo  <= '0;
              e   <= '0;
              if (count_after <= CNT_W'(1)) begin
                state <= S_EMIT_RD;
              end else begin
                state <= S_SETUP;
              end
            end
          end
        end
        S_SETUP: begin
          mid   <= mid_c;
          hi    <= hi_c;
          i     <= lo;
          j     <= mid_c;
          k     <= lo;
          state <= S_RDA;
        end
        S_RDA: begin
          a     <= rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          b     <= rdata;
          state <= S_MERGE;
        end
        S_MERGE: begin
          k <= k_inc;
          if (take_a) begin
            i <= i_inc;
          end else begin
            j <= j_inc;
          end
          if (k_inc == hi) begin
            if (lo_2w >= n_ext) begin
              // end of pass: swap buffers, double the run width
              sel <= !sel;
              w   <= w2;
              lo  <= '0;
              e   <= '0;
              if (w2 >= n_ext) begin
                state <= S_EMIT_RD;
              end else begin
                state <= S_SETUP;
              end
            end else begin
              lo    <= lo_2w[CNT_W-1:0];
              state <= S_SETUP;
            end
          end else if (take_a) begin
            state <= (i_inc < mid) ? S_FILLA : S_MERGE;
          end else begin
            state <= (j_inc < hi) ? S_FILLB : S_MERGE;
          end
        end
        S_FILLA: begin
          a     <= rdata;
          state <= S_MERGE;
        end
        S_FILLB: begin
          b     <= rdata;
          state <= S_MERGE;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (e_inc == count) begin
            count <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            e     <= e_inc;
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = state != S_IDLE;
  assign strobe              = state == S_EMIT_OUT;
  assign result.sorted_value = rdata;
  assign result.end_of_set   = e_inc == count;
  assign result.overflow     = ovf;

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat outside a sort");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.end_of_set) |=> !busy)
    else $error("engine still busy after the final beat");

  a_merge_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> ((k < hi) && (a_ok || b_ok)))
    else $error("merge step with no element left");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (count <= CNT_W'(MAX_ITEMS)))
    else $error("element count beyond capacity");

  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (e < count))
    else $error("emit index beyond the set");

endmodule
